FILE: sv/rpma_pkg.sv
// shared types and constants for the rms / phase meter accumulator
// no dependencies; imported by rpma_regs and rms_phase_meter_accumulator
package rpma_pkg;

  localparam int SAMPLE_BITS = 12;
  // deviation width covers both the sample and the 12-bit zero level
  localparam int DEV_W      = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;
  localparam int SQ_W       = 2 * DEV_W;
  localparam int S_TDATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;

  localparam int ACC_W      = 36;
  localparam int OFS_W      = 31;
  localparam int PHASE_W    = 30;
  localparam int XCNT_W     = 19;
  localparam int IDX_W      = 12;
  localparam int WCNT_W     = 6;
  localparam int TIME_W     = 17;
  localparam int M_TDATA_W  = 176;

  localparam int PADDR_W    = 5;
  localparam int PDATA_W    = 32;

  // register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_CUR_ZERO  = 3'd0;
  localparam logic [2:0] REG_CUR_BAND  = 3'd1;
  localparam logic [2:0] REG_VOL_ZERO  = 3'd2;
  localparam logic [2:0] REG_VOL_BAND  = 3'd3;
  localparam logic [2:0] REG_WIN_LEN   = 3'd4;
  localparam logic [2:0] REG_WIN_PER   = 3'd5;
  localparam logic [2:0] REG_TIME_WRAP = 3'd6;

  typedef struct packed {
    logic [11:0] current_zero_level;
    logic [11:0] current_band_half;
    logic [11:0] voltage_zero_level;
    logic [11:0] voltage_band_half;
    logic [12:0] window_length;
    logic [6:0]  windows_per_report;
    logic [16:0] timestamp_wrap;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    current_zero_level: 12'd1940,
    current_band_half:  12'd10,
    voltage_zero_level: 12'd2048,
    voltage_band_half:  12'd4,
    window_length:      13'd1000,
    windows_per_report: 7'd40,
    timestamp_wrap:     17'd86400
  };

endpackage

FILE: sv/rpma_regs.sv
// apb configuration registers for the rms / phase meter accumulator
// depends on rpma_pkg
module rpma_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rpma_pkg::PADDR_W-1:0] paddr,
  input  logic [rpma_pkg::PDATA_W-1:0] pwdata,
  output logic [rpma_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output rpma_pkg::cfg_t              cfg
);
  import rpma_pkg::*;

  logic [2:0] reg_sel;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_CUR_ZERO:  cfg.current_zero_level <= pwdata[11:0];
        REG_CUR_BAND:  cfg.current_band_half  <= pwdata[11:0];
        REG_VOL_ZERO:  cfg.voltage_zero_level <= pwdata[11:0];
        REG_VOL_BAND:  cfg.voltage_band_half  <= pwdata[11:0];
        REG_WIN_LEN:   cfg.window_length      <= pwdata[12:0];
        REG_WIN_PER:   cfg.windows_per_report <= pwdata[6:0];
        REG_TIME_WRAP: cfg.timestamp_wrap     <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CUR_ZERO:  prdata = PDATA_W'(cfg.current_zero_level);
      REG_CUR_BAND:  prdata = PDATA_W'(cfg.current_band_half);
      REG_VOL_ZERO:  prdata = PDATA_W'(cfg.voltage_zero_level);
      REG_VOL_BAND:  prdata = PDATA_W'(cfg.voltage_band_half);
      REG_WIN_LEN:   prdata = PDATA_W'(cfg.window_length);
      REG_WIN_PER:   prdata = PDATA_W'(cfg.windows_per_report);
      REG_TIME_WRAP: prdata = PDATA_W'(cfg.timestamp_wrap);
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: sv/rms_phase_meter_accumulator.sv
// top level of the rms / phase meter accumulator: input register, deviation, square and
// accumulate logic, result register; depends on rpma_pkg and rpma_regs
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata: current_sample, voltage_sample
// m_*       out  m_tvalid/m_tready  tdata: window sums and report fields; tlast: report_last
// apb       in   psel/penable       register writes and reads, pready tied high
//
// one sample pair per cycle unless a closing sample waits; a transfer loads the input
// register, from which the sample is folded into the sums or into the window result
// a sample that closes a window waits in the input register while the previous result
// is held by m_tready low, and s_tready drops; other samples keep flowing
// reset clears all accumulators, counters, crossing times and the timestamp
module rms_phase_meter_accumulator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [11:0] current_sample, [23:12] voltage_sample
  input  logic [rpma_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [35:0] voltage_sumsq, [71:36] current_sumsq, [77:72] window_index,
  // [94:78] report_time, [125:95] offset_sum, [155:126] phase_sum,
  // [174:156] crossing_count, [175] zero
  output logic [rpma_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                          m_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rpma_pkg::PADDR_W-1:0]   paddr,
  input  logic [rpma_pkg::PDATA_W-1:0]   pwdata,
  output logic [rpma_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import rpma_pkg::*;

  cfg_t cfg;

  rpma_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  logic                   in_valid;
  logic [SAMPLE_BITS-1:0] in_cur;
  logic [SAMPLE_BITS-1:0] in_vol;

  // running state
  logic [IDX_W-1:0]   sample_index;
  logic [WCNT_W-1:0]  window_count;
  logic [ACC_W-1:0]   voltage_acc;
  logic [ACC_W-1:0]   current_acc;
  logic [OFS_W-1:0]   offset_acc;
  logic [PHASE_W-1:0] phase_acc;
  logic [XCNT_W-1:0]  crossing_acc;
  logic [IDX_W-1:0]   voltage_cross_time;
  logic [IDX_W-1:0]   current_cross_time;
  logic [TIME_W-1:0]  time_count;

  logic in_free, in_go, emit, last;

  // deviations, band tests and squares
  logic [DEV_W-1:0] cur_ext, vol_ext, czero_ext, vzero_ext;
  logic [DEV_W-1:0] cdev, vdev;
  logic             vneg;
  logic             cband, vband;
  logic [SQ_W-1:0]  cur_sq, vol_sq;

  always_comb begin
    cur_ext   = DEV_W'(in_cur);
    vol_ext   = DEV_W'(in_vol);
    czero_ext = DEV_W'(cfg.current_zero_level);
    vzero_ext = DEV_W'(cfg.voltage_zero_level);
    cdev      = (cur_ext >= czero_ext) ? cur_ext - czero_ext : czero_ext - cur_ext;
    vneg      = vol_ext < vzero_ext;
    vdev      = vneg ? vzero_ext - vol_ext : vol_ext - vzero_ext;
    cband     = cdev <= DEV_W'(cfg.current_band_half);
    vband     = vdev <= DEV_W'(cfg.voltage_band_half);
    cur_sq    = SQ_W'(cdev) * SQ_W'(cdev);
    vol_sq    = SQ_W'(vdev) * SQ_W'(vdev);
  end

  // window and report limits, clamped
  logic [12:0] wlen;
  logic [6:0]  wpr;
  logic [12:0] idx_inc;
  logic [6:0]  wcnt_inc;
  logic [17:0] time_inc;

  always_comb begin
    if (cfg.window_length == 13'd0) begin
      wlen = 13'd1;
    end else if (cfg.window_length > 13'd4096) begin
      wlen = 13'd4096;
    end else begin
      wlen = cfg.window_length;
    end
    if (cfg.windows_per_report == 7'd0) begin
      wpr = 7'd1;
    end else if (cfg.windows_per_report > 7'd64) begin
      wpr = 7'd64;
    end else begin
      wpr = cfg.windows_per_report;
    end
    idx_inc  = 13'(sample_index) + 13'd1;
    wcnt_inc = 7'(window_count) + 7'd1;
    time_inc = 18'(time_count) + 18'd1;
    emit     = idx_inc >= wlen;
    last     = wcnt_inc >= wpr;
  end

  // handshake: only a window-closing sample waits on the result register
  assign in_go    = in_valid && (!emit || !m_tvalid || m_tready);
  assign in_free  = !in_valid || in_go;
  assign s_tready = in_free;

  // accumulate
  logic [IDX_W-1:0]   vct_next, cct_next, xt_diff;
  logic [ACC_W-1:0]   vacc_next, cacc_next;
  logic [OFS_W-1:0]   ofs_next;
  logic [PHASE_W-1:0] phase_next;
  logic [XCNT_W-1:0]  xcnt_next;
  logic [TIME_W-1:0]  time_next;

  always_comb begin
    cct_next   = cband ? sample_index : current_cross_time;
    vct_next   = vband ? sample_index : voltage_cross_time;
    xt_diff    = (vct_next >= cct_next) ? vct_next - cct_next : cct_next - vct_next;
    vacc_next  = voltage_acc + ACC_W'(vol_sq);
    cacc_next  = current_acc + ACC_W'(cur_sq);
    ofs_next   = vneg ? offset_acc - OFS_W'(vdev) : offset_acc + OFS_W'(vdev);
    phase_next = phase_acc + PHASE_W'(xt_diff);
    xcnt_next  = vband ? crossing_acc + XCNT_W'(1) : crossing_acc;
    time_next  = (time_inc >= 18'(cfg.timestamp_wrap)) ? '0 : time_inc[TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_free) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && s_tvalid) begin
      in_cur <= s_tdata[SAMPLE_BITS-1:0];
      in_vol <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index       <= '0;
      window_count       <= '0;
      voltage_acc        <= '0;
      current_acc        <= '0;
      offset_acc         <= '0;
      phase_acc          <= '0;
      crossing_acc       <= '0;
      voltage_cross_time <= '0;
      current_cross_time <= '0;
      time_count         <= '0;
      m_tvalid           <= 1'b0;
    end else begin
      if (in_go && emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (in_go) begin
        current_cross_time <= cct_next;
        voltage_cross_time <= vct_next;
        if (!emit) begin
          sample_index <= idx_inc[IDX_W-1:0];
          voltage_acc  <= vacc_next;
          current_acc  <= cacc_next;
          offset_acc   <= ofs_next;
          phase_acc    <= phase_next;
          crossing_acc <= xcnt_next;
        end else begin
          sample_index <= '0;
          voltage_acc  <= '0;
          current_acc  <= '0;
          if (!last) begin
            window_count <= wcnt_inc[WCNT_W-1:0];
            offset_acc   <= ofs_next;
            phase_acc    <= phase_next;
            crossing_acc <= xcnt_next;
          end else begin
            window_count <= '0;
            time_count   <= time_next;
            offset_acc   <= '0;
            phase_acc    <= '0;
            crossing_acc <= '0;
          end
        end
      end
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (in_go && emit) begin
      m_tdata[35:0]   <= vacc_next;
      m_tdata[71:36]  <= cacc_next;
      m_tdata[77:72]  <= window_count;
      m_tdata[175]    <= 1'b0;
      m_tlast         <= last;
      if (last) begin
        m_tdata[94:78]   <= time_next;
        m_tdata[125:95]  <= ofs_next;
        m_tdata[155:126] <= phase_next;
        m_tdata[174:156] <= xcnt_next;
      end else begin
        m_tdata[174:78]  <= '0;
      end
    end
  end

endmodule
